/* rtl/pn3f_pkg.sv */
// ----------------------------------------------------------------------------
// pn3f_pkg: shared definitions for the fractal 3D gradient noise block
// Sequencer states, datapath destination codes, opcodes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pn3f_pkg;

	localparam int TABLE_SIZE      = 256;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	// Q16.16 unity for frequency and amplitude.
	localparam int Q16_ONE = 65536;

	localparam logic       OP_LOAD = 1'b0;
	localparam logic       OP_EVAL = 1'b1;

	localparam logic [1:0] CFG_OCTAVES = 2'd0;
	localparam logic [1:0] CFG_PERSIST = 2'd1;
	localparam logic [1:0] CFG_LACUN   = 2'd2;

	localparam logic [3:0]  RST_OCTAVES = 4'd1;
	localparam logic [15:0] RST_PERSIST = 16'd32768;
	localparam logic [15:0] RST_LACUN   = 16'd512;

	// Gradient selection codes of the improved noise hash.
	localparam logic [3:0] GRAD_U_FROM_Y = 4'd8;
	localparam logic [3:0] GRAD_V_FROM_Y = 4'd4;
	localparam logic [3:0] GRAD_V_X_A    = 4'd12;
	localparam logic [3:0] GRAD_V_X_B    = 4'd14;

	// Last sequencer step of one octave.
	localparam logic [4:0] LAST_STEP = 5'd30;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OCTAVE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	typedef enum logic [4:0] {
		DST_NONE,
		DST_PX, DST_PY, DST_PZ,
		DST_INX, DST_INY, DST_INZ,
		DST_TTX, DST_TTY, DST_TTZ,
		DST_T3X, DST_T3Y, DST_T3Z,
		DST_U, DST_V, DST_W,
		DST_L0, DST_L1, DST_L2, DST_L3,
		DST_M0, DST_M1,
		DST_NV, DST_TOT, DST_AMP, DST_FREQ
	} dst_t;

	typedef enum logic [3:0] {
		RD_A, RD_B, RD_AA, RD_AB, RD_BA, RD_BB,
		RD_H0, RD_H1, RD_H2, RD_H3, RD_H4, RD_H5, RD_H6, RD_H7
	} rd_dst_t;

endpackage

/* rtl/perlin_noise_3d_fractal.sv */
// ----------------------------------------------------------------------------
// perlin_noise_3d_fractal: fractal 3D improved gradient noise
// One shared multiplier and the permutation memory run under a step sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: opcode; tdata: index, value, x, y, z
//  m_axis    out  m_axis_tvalid/tready       tdata: noise_value
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A load request writes one table entry. An evaluate request runs the step
// sequencer once per octave, with steps set by the shared multiplier and the
// chained table reads, then a bit-serial division, then loads the output
// register. Reset clears control state and restores the registers; the table
// is not cleared. The input waits while an evaluation runs or a finished
// result cannot enter a full output register.
`timescale 1ns / 1ps

module perlin_noise_3d_fractal #(
	parameter int MAX_OCTAVES = pn3f_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = pn3f_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [7:0] table_index, [15:8] table_value, [47:16] coord_x,
	// [79:48] coord_y, [111:80] coord_z
	input  logic [111:0] s_axis_tdata,
	// [0] opcode
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] noise_value
	output logic [15:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int VW = FRAC_BITS + 6;
	localparam int MW = 34;
	localparam int PW = 2 * MW;
	localparam int LW = $clog2(MAX_OCTAVES) + 1;
	localparam int TW = VW + LW;
	localparam int DW = 18 + LW;
	localparam int SH = 31 - FRAC_BITS;
	localparam int NW = TW + SH;
	localparam int CW = $clog2(NW + 1);
	localparam int ONE_I = 1 << FRAC_BITS;
	localparam logic signed [VW-1:0] ONE_V = VW'(ONE_I);
	localparam logic signed [VW-1:0] K15 = VW'(15 * ONE_I);
	localparam logic signed [VW-1:0] K10 = VW'(10 * ONE_I);
	localparam logic [4:0] MAXO = 5'(MAX_OCTAVES);

	pn3f_pkg::state_t state_q, state_d;

	logic [3:0]  octaves_q;
	logic [15:0] persist_q;
	logic [15:0] lacun_q;

	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [31:0] px_q, py_q, pz_q;
	logic [31:0] freq_q;
	logic [16:0] amp_q;
	logic [DW-1:0] maxv_q;
	logic signed [TW-1:0] total_q;
	logic [4:0] step_q;
	logic [4:0] oct_q;
	logic [4:0] noct_q;

	logic signed [VW-1:0] inx_q, iny_q, inz_q, ttx_q, tty_q, ttz_q;
	logic signed [VW-1:0] t3x_q, t3y_q, t3z_q, u_q, v_q, w_q;
	logic signed [VW-1:0] l0_q, l1_q, l2_q, l3_q, m0_q, m1_q, nv_q, la_q;
	logic [7:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	logic [3:0] h_q [8];

	logic signed [PW-1:0] prod_q;
	pn3f_pkg::dst_t prod_dst_q;

	logic [7:0] mem [pn3f_pkg::TABLE_SIZE];
	logic [7:0] rd_q;
	logic       rd_vld_q;
	pn3f_pkg::rd_dst_t rd_dst_q;

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [15:0]   quo_q;
	logic          ovf_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   out_q;
	logic          out_vld_q;

	// Sequencer issue signals.
	logic signed [MW-1:0] mul_a, mul_b;
	pn3f_pkg::dst_t mul_dst;
	logic signed [VW-1:0] la_d;
	logic       rd_en;
	logic [7:0] rd_addr;
	pn3f_pkg::rd_dst_t rd_dst;

	logic in_acc, eval_acc, oct_done, last_oct, div_done, out_free;
	logic [4:0] n_cfg;

	function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
			input logic signed [VW-1:0] gx, input logic signed [VW-1:0] gy,
			input logic signed [VW-1:0] gz);
		logic signed [VW-1:0] gu, gv;
		gu = (h < pn3f_pkg::GRAD_U_FROM_Y) ? gx : gy;
		if (h < pn3f_pkg::GRAD_V_FROM_Y) begin
			gv = gy;
		end else if (h == pn3f_pkg::GRAD_V_X_A || h == pn3f_pkg::GRAD_V_X_B) begin
			gv = gx;
		end else begin
			gv = gz;
		end
		grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
	endfunction

	// Lattice fractions, and the same minus one.
	logic signed [VW-1:0] fx, fy, fz, fx1, fy1, fz1;
	logic [7:0] cellx, celly, cellz;
	assign fx = VW'($signed({1'b0, px_q[FRAC_BITS-1:0]}));
	assign fy = VW'($signed({1'b0, py_q[FRAC_BITS-1:0]}));
	assign fz = VW'($signed({1'b0, pz_q[FRAC_BITS-1:0]}));
	assign fx1 = fx - ONE_V;
	assign fy1 = fy - ONE_V;
	assign fz1 = fz - ONE_V;
	assign cellx = px_q[FRAC_BITS+7:FRAC_BITS];
	assign celly = py_q[FRAC_BITS+7:FRAC_BITS];
	assign cellz = pz_q[FRAC_BITS+7:FRAC_BITS];

	logic signed [VW-1:0] g_lo, g_hi;
	always_comb begin
		g_lo = '0;
		g_hi = '0;
		unique case (step_q)
			5'd18: begin
				g_lo = grad(h_q[0], fx, fy, fz);
				g_hi = grad(h_q[1], fx1, fy, fz);
			end
			5'd19: begin
				g_lo = grad(h_q[2], fx, fy1, fz);
				g_hi = grad(h_q[3], fx1, fy1, fz);
			end
			5'd20: begin
				g_lo = grad(h_q[4], fx, fy, fz1);
				g_hi = grad(h_q[5], fx1, fy, fz1);
			end
			5'd21: begin
				g_lo = grad(h_q[6], fx, fy1, fz1);
				g_hi = grad(h_q[7], fx1, fy1, fz1);
			end
			default: begin
				g_lo = '0;
				g_hi = '0;
			end
		endcase
	end

	// Issue table: at most one multiply and one table read per step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_dst = pn3f_pkg::DST_NONE;
		la_d = la_q;
		rd_en = 1'b0;
		rd_addr = '0;
		rd_dst = pn3f_pkg::RD_A;
		if (state_q == pn3f_pkg::ST_OCTAVE) begin
			unique case (step_q)
				5'd0: begin
					mul_a = MW'(cx_q);
					mul_b = MW'($signed({1'b0, freq_q}));
					mul_dst = pn3f_pkg::DST_PX;
				end
				5'd1: begin
					mul_a = MW'(cy_q);
					mul_b = MW'($signed({1'b0, freq_q}));
					mul_dst = pn3f_pkg::DST_PY;
				end
				5'd2: begin
					mul_a = MW'(cz_q);
					mul_b = MW'($signed({1'b0, freq_q}));
					mul_dst = pn3f_pkg::DST_PZ;
				end
				5'd3: begin
					mul_a = MW'(fx);
					mul_b = MW'((fx <<< 2) + (fx <<< 1) - K15);
					mul_dst = pn3f_pkg::DST_INX;
				end
				5'd4: begin
					mul_a = MW'(fx);
					mul_b = MW'(fx);
					mul_dst = pn3f_pkg::DST_TTX;
				end
				5'd5: begin
					mul_a = MW'(fy);
					mul_b = MW'((fy <<< 2) + (fy <<< 1) - K15);
					mul_dst = pn3f_pkg::DST_INY;
				end
				5'd6: begin
					mul_a = MW'(fy);
					mul_b = MW'(fy);
					mul_dst = pn3f_pkg::DST_TTY;
				end
				5'd7: begin
					mul_a = MW'(fz);
					mul_b = MW'((fz <<< 2) + (fz <<< 1) - K15);
					mul_dst = pn3f_pkg::DST_INZ;
				end
				5'd8: begin
					mul_a = MW'(fz);
					mul_b = MW'(fz);
					mul_dst = pn3f_pkg::DST_TTZ;
				end
				5'd9: begin
					mul_a = MW'(ttx_q);
					mul_b = MW'(fx);
					mul_dst = pn3f_pkg::DST_T3X;
				end
				5'd10: begin
					mul_a = MW'(tty_q);
					mul_b = MW'(fy);
					mul_dst = pn3f_pkg::DST_T3Y;
				end
				5'd11: begin
					mul_a = MW'(ttz_q);
					mul_b = MW'(fz);
					mul_dst = pn3f_pkg::DST_T3Z;
				end
				5'd12: begin
					mul_a = MW'(t3x_q);
					mul_b = MW'(inx_q);
					mul_dst = pn3f_pkg::DST_U;
				end
				5'd13: begin
					mul_a = MW'(t3y_q);
					mul_b = MW'(iny_q);
					mul_dst = pn3f_pkg::DST_V;
				end
				5'd14: begin
					mul_a = MW'(t3z_q);
					mul_b = MW'(inz_q);
					mul_dst = pn3f_pkg::DST_W;
				end
				5'd18, 5'd19, 5'd20, 5'd21: begin
					mul_a = MW'(u_q);
					mul_b = MW'(g_hi - g_lo);
					la_d = g_lo;
					unique case (step_q[1:0])
						2'd2: mul_dst = pn3f_pkg::DST_L0;
						2'd3: mul_dst = pn3f_pkg::DST_L1;
						2'd0: mul_dst = pn3f_pkg::DST_L2;
						default: mul_dst = pn3f_pkg::DST_L3;
					endcase
				end
				5'd22: begin
					mul_a = MW'(v_q);
					mul_b = MW'(l1_q - l0_q);
					la_d = l0_q;
					mul_dst = pn3f_pkg::DST_M0;
				end
				5'd23: begin
					mul_a = MW'(v_q);
					mul_b = MW'(l3_q - l2_q);
					la_d = l2_q;
					mul_dst = pn3f_pkg::DST_M1;
				end
				5'd25: begin
					mul_a = MW'(w_q);
					mul_b = MW'(m1_q - m0_q);
					la_d = m0_q;
					mul_dst = pn3f_pkg::DST_NV;
				end
				5'd27: begin
					mul_a = MW'(nv_q);
					mul_b = MW'($signed({1'b0, amp_q}));
					mul_dst = pn3f_pkg::DST_TOT;
				end
				5'd28: begin
					mul_a = MW'($signed({1'b0, amp_q}));
					mul_b = MW'($signed({1'b0, persist_q}));
					mul_dst = pn3f_pkg::DST_AMP;
				end
				5'd29: begin
					mul_a = MW'($signed({1'b0, freq_q}));
					mul_b = MW'($signed({1'b0, lacun_q}));
					mul_dst = pn3f_pkg::DST_FREQ;
				end
				default: begin
					mul_dst = pn3f_pkg::DST_NONE;
				end
			endcase

			// Hash chain reads; each address uses values written back earlier.
			rd_en = (step_q >= 5'd3) && (step_q <= 5'd16);
			unique case (step_q)
				5'd3:  begin rd_addr = cellx;                rd_dst = pn3f_pkg::RD_A;  end
				5'd4:  begin rd_addr = cellx + 8'd1;         rd_dst = pn3f_pkg::RD_B;  end
				5'd5:  begin rd_addr = a_q + celly;          rd_dst = pn3f_pkg::RD_AA; end
				5'd6:  begin rd_addr = a_q + celly + 8'd1;   rd_dst = pn3f_pkg::RD_AB; end
				5'd7:  begin rd_addr = b_q + celly;          rd_dst = pn3f_pkg::RD_BA; end
				5'd8:  begin rd_addr = b_q + celly + 8'd1;   rd_dst = pn3f_pkg::RD_BB; end
				5'd9:  begin rd_addr = aa_q + cellz;         rd_dst = pn3f_pkg::RD_H0; end
				5'd10: begin rd_addr = ba_q + cellz;         rd_dst = pn3f_pkg::RD_H1; end
				5'd11: begin rd_addr = ab_q + cellz;         rd_dst = pn3f_pkg::RD_H2; end
				5'd12: begin rd_addr = bb_q + cellz;         rd_dst = pn3f_pkg::RD_H3; end
				5'd13: begin rd_addr = aa_q + cellz + 8'd1;  rd_dst = pn3f_pkg::RD_H4; end
				5'd14: begin rd_addr = ba_q + cellz + 8'd1;  rd_dst = pn3f_pkg::RD_H5; end
				5'd15: begin rd_addr = ab_q + cellz + 8'd1;  rd_dst = pn3f_pkg::RD_H6; end
				5'd16: begin rd_addr = bb_q + cellz + 8'd1;  rd_dst = pn3f_pkg::RD_H7; end
				default: begin rd_addr = '0;                 rd_dst = pn3f_pkg::RD_A;  end
			endcase
		end
	end

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign eval_acc = in_acc && (s_axis_tuser[0] == pn3f_pkg::OP_EVAL);
	assign oct_done = (state_q == pn3f_pkg::ST_OCTAVE) && (step_q == pn3f_pkg::LAST_STEP);
	assign last_oct = (oct_q == noct_q - 5'd1);
	assign div_done = (state_q == pn3f_pkg::ST_DIVIDE) && (cnt_q == CW'(NW - 1));
	assign out_free = !out_vld_q || m_axis_tready;

	assign n_cfg = (octaves_q == 4'd0) ? 5'd1
		: (({1'b0, octaves_q} > MAXO) ? MAXO : {1'b0, octaves_q});

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pn3f_pkg::ST_IDLE:   if (eval_acc) state_d = pn3f_pkg::ST_OCTAVE;
			pn3f_pkg::ST_OCTAVE: if (oct_done && last_oct) state_d = pn3f_pkg::ST_DIVIDE;
			pn3f_pkg::ST_DIVIDE: if (div_done) state_d = pn3f_pkg::ST_FINISH;
			pn3f_pkg::ST_FINISH: if (out_free) state_d = pn3f_pkg::ST_IDLE;
			default:             state_d = pn3f_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		s_axis_tready = (state_q == pn3f_pkg::ST_IDLE);
		cfg_ready     = 1'b1;
		m_axis_tvalid = out_vld_q;
		m_axis_tdata  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pn3f_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= pn3f_pkg::RST_OCTAVES;
			persist_q <= pn3f_pkg::RST_PERSIST;
			lacun_q   <= pn3f_pkg::RST_LACUN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pn3f_pkg::CFG_OCTAVES: octaves_q <= cfg_data[3:0];
				pn3f_pkg::CFG_PERSIST: persist_q <= cfg_data;
				pn3f_pkg::CFG_LACUN:   lacun_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Permutation memory.
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser[0] == pn3f_pkg::OP_LOAD) begin
			mem[s_axis_tdata[7:0]] <= s_axis_tdata[15:8];
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q   <= 1'b0;
			rd_dst_q   <= pn3f_pkg::RD_A;
			prod_dst_q <= pn3f_pkg::DST_NONE;
			step_q     <= '0;
			oct_q      <= '0;
			cnt_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_q   <= rd_en;
			rd_dst_q   <= rd_dst;
			prod_dst_q <= mul_dst;
			if (eval_acc) begin
				step_q <= '0;
				oct_q  <= '0;
			end else if (oct_done) begin
				step_q <= '0;
				oct_q  <= oct_q + 5'd1;
			end else if (state_q == pn3f_pkg::ST_OCTAVE) begin
				step_q <= step_q + 5'd1;
			end
			if (state_q == pn3f_pkg::ST_DIVIDE) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (state_q == pn3f_pkg::ST_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	logic signed [VW-1:0] fm_v;
	logic [DW:0] rem_sh;
	logic        rem_ge;
	logic [TW-1:0] mag;
	logic          sat;
	assign fm_v   = VW'(prod_q >>> FRAC_BITS);
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign rem_ge = rem_sh >= {1'b0, maxv_q};
	assign mag    = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
	assign sat    = ovf_q || quo_q[15];

	// Datapath: multiplier, write-back by destination code, divider.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		la_q   <= la_d;
		if (eval_acc) begin
			cx_q    <= $signed(s_axis_tdata[47:16]);
			cy_q    <= $signed(s_axis_tdata[79:48]);
			cz_q    <= $signed(s_axis_tdata[111:80]);
			freq_q  <= 32'(pn3f_pkg::Q16_ONE);
			amp_q   <= 17'(pn3f_pkg::Q16_ONE);
			total_q <= '0;
			maxv_q  <= '0;
			noct_q  <= n_cfg;
		end
		if (state_q == pn3f_pkg::ST_OCTAVE && step_q == 5'd27) begin
			maxv_q <= maxv_q + DW'(amp_q);
		end
		unique case (prod_dst_q)
			pn3f_pkg::DST_PX:  px_q  <= prod_q[47:16];
			pn3f_pkg::DST_PY:  py_q  <= prod_q[47:16];
			pn3f_pkg::DST_PZ:  pz_q  <= prod_q[47:16];
			pn3f_pkg::DST_INX: inx_q <= fm_v + K10;
			pn3f_pkg::DST_INY: iny_q <= fm_v + K10;
			pn3f_pkg::DST_INZ: inz_q <= fm_v + K10;
			pn3f_pkg::DST_TTX: ttx_q <= fm_v;
			pn3f_pkg::DST_TTY: tty_q <= fm_v;
			pn3f_pkg::DST_TTZ: ttz_q <= fm_v;
			pn3f_pkg::DST_T3X: t3x_q <= fm_v;
			pn3f_pkg::DST_T3Y: t3y_q <= fm_v;
			pn3f_pkg::DST_T3Z: t3z_q <= fm_v;
			pn3f_pkg::DST_U:   u_q   <= fm_v;
			pn3f_pkg::DST_V:   v_q   <= fm_v;
			pn3f_pkg::DST_W:   w_q   <= fm_v;
			pn3f_pkg::DST_L0:  l0_q  <= la_q + fm_v;
			pn3f_pkg::DST_L1:  l1_q  <= la_q + fm_v;
			pn3f_pkg::DST_L2:  l2_q  <= la_q + fm_v;
			pn3f_pkg::DST_L3:  l3_q  <= la_q + fm_v;
			pn3f_pkg::DST_M0:  m0_q  <= la_q + fm_v;
			pn3f_pkg::DST_M1:  m1_q  <= la_q + fm_v;
			pn3f_pkg::DST_NV:  nv_q  <= la_q + fm_v;
			pn3f_pkg::DST_TOT: total_q <= total_q + TW'(prod_q >>> 16);
			pn3f_pkg::DST_AMP: amp_q <= prod_q[32:16];
			pn3f_pkg::DST_FREQ: begin
				// Frequency saturates at the top of its 32-bit range.
				if (|prod_q[PW-1:40]) begin
					freq_q <= '1;
				end else begin
					freq_q <= prod_q[39:8];
				end
			end
			default: ;
		endcase
		if (rd_vld_q) begin
			unique case (rd_dst_q)
				pn3f_pkg::RD_A:  a_q  <= rd_q;
				pn3f_pkg::RD_B:  b_q  <= rd_q;
				pn3f_pkg::RD_AA: aa_q <= rd_q;
				pn3f_pkg::RD_AB: ab_q <= rd_q;
				pn3f_pkg::RD_BA: ba_q <= rd_q;
				pn3f_pkg::RD_BB: bb_q <= rd_q;
				pn3f_pkg::RD_H0: h_q[0] <= rd_q[3:0];
				pn3f_pkg::RD_H1: h_q[1] <= rd_q[3:0];
				pn3f_pkg::RD_H2: h_q[2] <= rd_q[3:0];
				pn3f_pkg::RD_H3: h_q[3] <= rd_q[3:0];
				pn3f_pkg::RD_H4: h_q[4] <= rd_q[3:0];
				pn3f_pkg::RD_H5: h_q[5] <= rd_q[3:0];
				pn3f_pkg::RD_H6: h_q[6] <= rd_q[3:0];
				pn3f_pkg::RD_H7: h_q[7] <= rd_q[3:0];
				default: ;
			endcase
		end
		// The divider works on the magnitude; a quotient of 2^15 or more
		// only needs to be flagged, since the result saturates.
		if (oct_done && last_oct) begin
			num_q <= NW'(mag) << SH;
			neg_q <= total_q[TW-1];
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == pn3f_pkg::ST_DIVIDE) begin
			num_q <= num_q << 1;
			rem_q <= rem_ge ? DW'(rem_sh - {1'b0, maxv_q}) : DW'(rem_sh);
			quo_q <= {quo_q[14:0], rem_ge};
			ovf_q <= ovf_q || quo_q[15];
		end
		if (state_q == pn3f_pkg::ST_FINISH && out_free) begin
			if (neg_q) begin
				out_q <= sat ? 16'h8000 : 16'(-quo_q);
			end else begin
				out_q <= sat ? 16'h7fff : quo_q;
			end
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pn3f_pkg::ST_DIVIDE |-> rem_q < maxv_q)
		else $error("divider remainder not below divisor");
	a_amp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pn3f_pkg::ST_DIVIDE |-> maxv_q >= DW'(pn3f_pkg::Q16_ONE))
		else $error("total amplitude below one");
	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		eval_acc |=> state_q == pn3f_pkg::ST_OCTAVE && step_q == 5'd0)
		else $error("evaluate request did not start the sequencer");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pn3f_pkg::ST_OCTAVE |-> step_q <= pn3f_pkg::LAST_STEP && oct_q < noct_q)
		else $error("sequencer step or octave out of range");

endmodule
